### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hdl/msam_pkg.sv
// ---------------------------------------------------------------------------
// msam_pkg
// Shared types, constants and helpers of the multi-slot alarm matcher.
// ---------------------------------------------------------------------------
package msam_pkg;

    localparam int ALARM_SLOTS    = 8;
    localparam int SLOTS_PER_WORD = 4;
    localparam int SLOT_BITS      = 16;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int COUNT_W        = 4;
    localparam int MOD_W          = 11;
    localparam int SLOT_W         = 3;
    localparam int HOUR_W         = 5;
    localparam int MIN_W          = 6;

    localparam logic [MOD_W-1:0]  MIN_PER_DAY = 11'd1440;
    localparam logic [HOUR_W-1:0] HOUR_MAX    = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_MAX     = 6'd59;

    typedef enum logic [1:0] {
        OP_POLL   = 2'd0,
        OP_WINDOW = 2'd1,
        OP_FORGET = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DND        = 2'd0,
        CFG_SLOT_COUNT = 2'd1,
        CFG_SLOTS_LO   = 2'd2,
        CFG_SLOTS_HI   = 2'd3
    } cfg_idx_t;

    // Decoded alarm slots as seen by the datapath.
    typedef struct packed {
        logic                               dnd;
        logic [ALARM_SLOTS-1:0]             active;
        logic [ALARM_SLOTS-1:0][MOD_W-1:0]  mod;
    } slot_table_t;

    // Soonest-alarm candidate / result.
    typedef struct packed {
        logic               valid;
        logic [MOD_W-1:0]   gap;
        logic [SLOT_W-1:0]  slot;
    } nearest_t;

    typedef struct packed {
        logic               ok;
        logic [MOD_W-1:0]   mod;
    } slot_entry_t;

    // Unpack one 16-bit slot: bit 11 enable, bits 10-6 hour, bits 5-0 minute.
    function automatic slot_entry_t slot_decode(input logic [SLOT_BITS-1:0] bits);
        slot_entry_t       e;
        logic [HOUR_W-1:0] h;
        logic [MIN_W-1:0]  m;
        h     = bits[10:6];
        m     = bits[5:0];
        e.ok  = bits[11] && (h <= HOUR_MAX) && (m <= MIN_MAX);
        e.mod = MOD_W'(MOD_W'(h) * MOD_W'(60)) + MOD_W'(m);
        return e;
    endfunction

    // Minute of day from a clock reading, saturating out-of-range fields.
    function automatic logic [MOD_W-1:0] clock_minute(input logic [HOUR_W-1:0] h,
                                                       input logic [MIN_W-1:0]  m);
        logic [HOUR_W-1:0] hs;
        logic [MIN_W-1:0]  ms;
        hs = (h > HOUR_MAX) ? HOUR_MAX : h;
        ms = (m > MIN_MAX) ? MIN_MAX : m;
        return MOD_W'(MOD_W'(hs) * MOD_W'(60)) + MOD_W'(ms);
    endfunction

    // (a - b) mod one day, both operands below one day.
    function automatic logic [MOD_W-1:0] day_sub(input logic [MOD_W-1:0] a,
                                                  input logic [MOD_W-1:0] b);
        logic [MOD_W:0] wrapped;
        wrapped = {1'b0, a} + {1'b0, MIN_PER_DAY} - {1'b0, b};
        return (a >= b) ? (a - b) : wrapped[MOD_W-1:0];
    endfunction

endpackage

### hdl/msam_slot_table.sv
// ---------------------------------------------------------------------------
// msam_slot_table
// Configuration registers; slot words are decoded as they are written.
// ---------------------------------------------------------------------------
module msam_slot_table
    import msam_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output slot_table_t           slots
);

    logic               dnd_reg;
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dnd_reg   <= 1'b0;
            count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DND:        dnd_reg   <= cfg_wdata[0];
                CFG_SLOT_COUNT: count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign slots.dnd = dnd_reg;

    for (genvar g = 0; g < ALARM_SLOTS; g++) begin : g_slot
        localparam int       WORD_SEL = g / SLOTS_PER_WORD;
        localparam int       LSB      = (g % SLOTS_PER_WORD) * SLOT_BITS;
        localparam cfg_idx_t WORD_IDX = (WORD_SEL == 0) ? CFG_SLOTS_LO : CFG_SLOTS_HI;

        slot_entry_t entry_reg;

        // Decode on write so the datapath sees ready-made minutes of day.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                entry_reg <= '0;
            end else if (cfg_we && (cfg_idx_t'(cfg_index) == WORD_IDX)) begin
                entry_reg <= slot_decode(cfg_wdata[LSB +: SLOT_BITS]);
            end
        end

        assign slots.active[g] = entry_reg.ok && (COUNT_W'(g) < count_reg);
        assign slots.mod[g]    = entry_reg.mod;
    end

endmodule

### hdl/msam_match.sv
// ---------------------------------------------------------------------------
// msam_match
// Per-slot hit detection for the poll and window operations.
// ---------------------------------------------------------------------------
module msam_match
    import msam_pkg::*;
(
    input  slot_table_t       slots,
    input  logic [MOD_W-1:0]  now,
    input  logic [MOD_W-1:0]  win_start,
    output logic              hit_now,
    output logic              hit_window
);

    logic [MOD_W-1:0]       span;
    logic [ALARM_SLOTS-1:0] eq_now;
    logic [ALARM_SLOTS-1:0] in_win;

    assign span = day_sub(now, win_start);

    always_comb begin
        for (int i = 0; i < ALARM_SLOTS; i++) begin
            eq_now[i] = slots.active[i] && (slots.mod[i] == now);
            in_win[i] = slots.active[i]
                        && (day_sub(slots.mod[i], win_start) != '0)
                        && (day_sub(slots.mod[i], win_start) < span);
        end
    end

    assign hit_now    = |eq_now;
    assign hit_window = |in_win;

endmodule

### hdl/msam_nearest.sv
// ---------------------------------------------------------------------------
// msam_nearest
// Minutes to the soonest active alarm; lowest slot wins ties.
// ---------------------------------------------------------------------------
module msam_nearest
    import msam_pkg::*;
(
    input  slot_table_t       slots,
    input  logic [MOD_W-1:0]  now,
    output nearest_t          best
);

    localparam int LEAVES = 1 << SLOT_W;

    nearest_t lvl0 [LEAVES];
    nearest_t lvl1 [LEAVES/2];
    nearest_t lvl2 [LEAVES/4];
    nearest_t top;

    // Keep the left (lower slot) candidate unless the right one is strictly closer.
    function automatic nearest_t pick(input nearest_t a, input nearest_t b);
        return (a.valid && (!b.valid || (a.gap <= b.gap))) ? a : b;
    endfunction

    for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < ALARM_SLOTS) begin : g_used
            logic [MOD_W:0] ahead;
            assign ahead = {1'b0, slots.mod[g]} + {1'b0, MIN_PER_DAY} - {1'b0, now};
            assign lvl0[g].valid = slots.active[g];
            assign lvl0[g].gap   = (slots.mod[g] > now) ? (slots.mod[g] - now)
                                                        : ahead[MOD_W-1:0];
            assign lvl0[g].slot  = SLOT_W'(g);
        end else begin : g_pad
            assign lvl0[g] = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < LEAVES/2; i++) lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
        for (int i = 0; i < LEAVES/4; i++) lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
        top = pick(lvl2[0], lvl2[1]);
    end

    // Report zeros when no slot is active.
    assign best = top.valid ? top : '0;

endmodule

### hdl/multi_slot_alarm_matcher_unit.sv
// ---------------------------------------------------------------------------
// multi_slot_alarm_matcher_unit
// Time-of-day alarm matcher over up to eight configured slots.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Contents
//  -------  ---------  -----------------  ----------------------------------------
//  s_       in         s_valid/s_ready    operation, hour, minute, window_start
//  m_       out        m_valid/m_ready    fire, next_valid, next_minutes, next_slot
//  cfg_     in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
//  Path: an accepted word passes the input register, then the result register.
//  Throughput: one word per cycle while no result is held; set by the single compare pass over all slots.
//  Reset: synchronous, active low; clears all config, the fired minute and both
//  valid flags. No clearing pass is needed.
//  Stalls: a held result stops the input register only; s_ready stays high
//  while the input register is empty or moving into the result register.
//
module multi_slot_alarm_matcher_unit
    import msam_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [HOUR_W-1:0]     s_hour,
    input  logic [MIN_W-1:0]      s_minute,
    input  logic [MOD_W-1:0]      s_window_start,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_fire,
    output logic                  m_next_valid,
    output logic [MOD_W-1:0]      m_next_minutes,
    output logic [SLOT_W-1:0]     m_next_slot
);

`include "assert_macros.svh"

    // -----------------------------------------------------------------------
    // Configuration and decoded slot table
    // -----------------------------------------------------------------------
    slot_table_t slots;

    msam_slot_table u_slot_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .slots     (slots)
    );

    // -----------------------------------------------------------------------
    // Input register
    // -----------------------------------------------------------------------
    logic              stg_valid_reg;
    op_t               stg_op_reg;
    logic [HOUR_W-1:0] stg_hour_reg;
    logic [MIN_W-1:0]  stg_minute_reg;
    logic [MOD_W-1:0]  stg_ws_reg;

    logic out_valid_reg;
    logic out_free;
    logic pipe_adv;
    logic in_take;

    // The result register can take a word when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign pipe_adv = stg_valid_reg && out_free;
    assign s_ready  = !stg_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (in_take) begin
            stg_valid_reg <= 1'b1;
        end else if (pipe_adv) begin
            stg_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; load only on accept.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            stg_op_reg     <= op_t'(s_operation);
            stg_hour_reg   <= s_hour;
            stg_minute_reg <= s_minute;
            stg_ws_reg     <= s_window_start;
        end
    end

    // -----------------------------------------------------------------------
    // Single pass: time of day, slot hits, soonest alarm
    // -----------------------------------------------------------------------
    logic [MOD_W-1:0] now;
    logic [MOD_W-1:0] win_start;
    logic             hit_now;
    logic             hit_window;
    nearest_t         best;

    assign now = clock_minute(stg_hour_reg, stg_minute_reg);
    // Wrap a window start of one day or more back into the day.
    assign win_start = (stg_ws_reg >= MIN_PER_DAY) ? (stg_ws_reg - MIN_PER_DAY) : stg_ws_reg;

    msam_match u_match (
        .slots      (slots),
        .now        (now),
        .win_start  (win_start),
        .hit_now    (hit_now),
        .hit_window (hit_window)
    );

    msam_nearest u_nearest (
        .slots (slots),
        .now   (now),
        .best  (best)
    );

    // -----------------------------------------------------------------------
    // Fired-minute memory and fire decision
    // -----------------------------------------------------------------------
    logic             fired_valid_reg;
    logic [MOD_W-1:0] fired_min_reg;
    logic             fired_valid_next;
    logic [MOD_W-1:0] fired_min_next;
    logic             already_fired;
    logic             fire_next;

    assign already_fired = fired_valid_reg && (fired_min_reg == now);

    always_comb begin
        fire_next        = 1'b0;
        fired_valid_next = fired_valid_reg;
        fired_min_next   = fired_min_reg;
        case (stg_op_reg)
            OP_POLL: begin
                // Drop a remembered minute once the clock has moved on.
                if (fired_valid_reg && (fired_min_reg != now)) begin
                    fired_valid_next = 1'b0;
                end
                if (!slots.dnd && !already_fired && hit_now) begin
                    fire_next        = 1'b1;
                    fired_valid_next = 1'b1;
                    fired_min_next   = now;
                end
            end
            OP_WINDOW: begin
                fire_next = !slots.dnd && hit_window;
            end
            OP_FORGET: begin
                fired_valid_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fired_valid_reg <= 1'b0;
            fired_min_reg   <= '0;
        end else if (pipe_adv) begin
            fired_valid_reg <= fired_valid_next;
            fired_min_reg   <= fired_min_next;
        end
    end

    // -----------------------------------------------------------------------
    // Result register
    // -----------------------------------------------------------------------
    logic              out_fire_reg;
    logic              out_next_valid_reg;
    logic [MOD_W-1:0]  out_minutes_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result while the consumer stalls; advance on pipe_adv only.
    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            out_fire_reg       <= fire_next;
            out_next_valid_reg <= best.valid;
            out_minutes_reg    <= best.gap;
            out_slot_reg       <= best.slot;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_fire         = out_fire_reg;
    assign m_next_valid   = out_next_valid_reg;
    assign m_next_minutes = out_minutes_reg;
    assign m_next_slot    = out_slot_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `ASSERT_CLK(a_poll_fire_marks, aclk, aresetn, pipe_adv && (stg_op_reg == OP_POLL) && fire_next |=> fired_valid_reg && (fired_min_reg == $past(now)), "poll fire did not record its minute")
    `ASSERT_CLK(a_forget_clears, aclk, aresetn, pipe_adv && (stg_op_reg == OP_FORGET) |=> !fired_valid_reg, "forget left a fired minute behind")
    `ASSERT_NEVER(a_dnd_silent, aclk, aresetn, pipe_adv && fire_next && slots.dnd, "fire while do-not-disturb is set")
    `ASSERT_NEVER(a_repeat_fire, aclk, aresetn, pipe_adv && (stg_op_reg == OP_POLL) && fire_next && already_fired, "second fire in the same minute")
    `ASSERT_CLK(a_none_is_zero, aclk, aresetn, out_valid_reg && !out_next_valid_reg |-> (out_minutes_reg == '0) && (out_slot_reg == '0), "empty result carries nonzero fields")
    `ASSERT_CLK(a_dist_range, aclk, aresetn, out_valid_reg && out_next_valid_reg |-> (out_minutes_reg != '0) && (out_minutes_reg <= MIN_PER_DAY), "distance outside one day")

endmodule

### tb/sv/msam_tb_pkg.sv
// ---------------------------------------------------------------------------
// msam_tb_pkg
// Result word type and alarm scoreboard for the multi-slot alarm matcher
// testbench. The scoreboard keeps its own copy of the slot table and of the
// fired-minute memory. It predicts every result word as its input word is
// accepted, and checks the result words in order.
// ---------------------------------------------------------------------------
package msam_tb_pkg;
    import msam_pkg::*;

    localparam int DAY_MINUTES = 24 * 60;

    typedef struct packed {
        logic              fire;
        logic              next_valid;
        logic [MOD_W-1:0]  next_minutes;
        logic [SLOT_W-1:0] next_slot;
    } alarm_word_t;

    class alarm_scoreboard;
        logic                  dnd;
        logic [COUNT_W-1:0]    slot_count;
        logic [CFG_DATA_W-1:0] slots_lo;
        logic [CFG_DATA_W-1:0] slots_hi;
        logic                  fired_valid;
        logic [MOD_W-1:0]      fired_minute;
        alarm_word_t           expected_words[$];
        int                    errors;

        function new();
            dnd          = 1'b0;
            slot_count   = '0;
            slots_lo     = '0;
            slots_hi     = '0;
            fired_valid  = 1'b0;
            fired_minute = '0;
            errors       = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DND:        dnd        = data[0];
                CFG_SLOT_COUNT: slot_count = data[COUNT_W-1:0];
                CFG_SLOTS_LO:   slots_lo   = data;
                CFG_SLOTS_HI:   slots_hi   = data;
                default: ;
            endcase
        endfunction

        // Minute of day of one slot; false when disabled or out of range.
        function bit slot_alarm(int i, output int unsigned at);
            logic [SLOT_BITS-1:0] bits;
            bits = (i < SLOTS_PER_WORD) ? slots_lo[(i % SLOTS_PER_WORD) * SLOT_BITS +: SLOT_BITS]
                                        : slots_hi[(i % SLOTS_PER_WORD) * SLOT_BITS +: SLOT_BITS];
            at = bits[10:6] * 60 + bits[5:0];
            return bits[11] && (bits[10:6] <= 23) && (bits[5:0] <= 59);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Predict the result word of one accepted input word.
        function void note_word(op_t op, logic [HOUR_W-1:0] hour, logic [MIN_W-1:0] minute,
                                logic [MOD_W-1:0] window_start);
            int unsigned now, start, span, gap, at, best, live;
            int          best_slot;
            bit          hit, found;
            alarm_word_t w;
            now   = ((hour > 23) ? 23 : hour) * 60 + ((minute > 59) ? 59 : minute);
            start = (window_start >= DAY_MINUTES) ? window_start - DAY_MINUTES : window_start;
            live  = (slot_count > ALARM_SLOTS) ? ALARM_SLOTS : slot_count;
            hit   = 1'b0;
            case (op)
                OP_POLL: begin
                    // a new minute forgets the old one
                    if (fired_valid && fired_minute != now)
                        fired_valid = 1'b0;
                    if (!dnd && !(fired_valid && fired_minute == now)) begin
                        for (int i = 0; i < live && !hit; i++)
                            if (slot_alarm(i, at) && at == now)
                                hit = 1'b1;
                        if (hit) begin
                            fired_valid  = 1'b1;
                            fired_minute = MOD_W'(now);
                        end
                    end
                end
                OP_WINDOW: begin
                    if (!dnd) begin
                        span = (now + DAY_MINUTES - start) % DAY_MINUTES;
                        for (int i = 0; i < live && !hit; i++)
                            if (slot_alarm(i, at)) begin
                                gap = (at + DAY_MINUTES - start) % DAY_MINUTES;
                                if (gap > 0 && gap < span)
                                    hit = 1'b1;
                            end
                    end
                end
                OP_FORGET: fired_valid = 1'b0;
                default: ;
            endcase

            // soonest alarm, lowest slot wins a tie
            found     = 1'b0;
            best      = 0;
            best_slot = 0;
            for (int i = 0; i < live; i++)
                if (slot_alarm(i, at)) begin
                    gap = (at > now) ? at - now : at + DAY_MINUTES - now;
                    if (!found || gap < best) begin
                        best      = gap;
                        best_slot = i;
                        found     = 1'b1;
                    end
                end

            w.fire         = hit;
            w.next_valid   = found;
            w.next_minutes = found ? MOD_W'(best) : '0;
            w.next_slot    = SLOT_W'(best_slot);
            expected_words.push_back(w);
        endfunction

        function void check_word(alarm_word_t got);
            alarm_word_t want;
            if (expected_words.size() == 0) begin
                errors++;
                $error("result word with no expectation pending");
                return;
            end
            want = expected_words.pop_front();
            if (got.fire !== want.fire) begin
                errors++;
                $error("fire: expected %0d, got %0d", want.fire, got.fire);
            end
            if (got.next_valid !== want.next_valid) begin
                errors++;
                $error("next_valid: expected %0d, got %0d", want.next_valid, got.next_valid);
            end
            if (got.next_minutes !== want.next_minutes) begin
                errors++;
                $error("next_minutes: expected %0d, got %0d", want.next_minutes,
                       got.next_minutes);
            end
            if (got.next_slot !== want.next_slot) begin
                errors++;
                $error("next_slot: expected %0d, got %0d", want.next_slot, got.next_slot);
            end
        endfunction
    endclass

endpackage

### tb/sv/multi_slot_alarm_matcher_unit_tb.sv
// ---------------------------------------------------------------------------
// multi_slot_alarm_matcher_unit_tb
// Self-checking testbench of the multi-slot alarm matcher. It runs a
// directed pass over the special cases. It then runs random phases with
// different slot tables, slot counts and do-not-disturb settings, and with
// sender gaps and receiver stalls. Every result word is checked against the
// scoreboard prediction.
// ---------------------------------------------------------------------------
module multi_slot_alarm_matcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msam_pkg::*;
    import msam_tb_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 240;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_operation    = '0;
    logic [HOUR_W-1:0]     s_hour         = '0;
    logic [MIN_W-1:0]      s_minute       = '0;
    logic [MOD_W-1:0]      s_window_start = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_fire;
    logic                  m_next_valid;
    logic [MOD_W-1:0]      m_next_minutes;
    logic [SLOT_W-1:0]     m_next_slot;

    alarm_scoreboard sb = new();

    // Percent chances of a sender gap and of a receiver stall per cycle.
    int send_idle_pct = 17;
    int stall_pct     = 17;
    // Set by the stimulus to ask for a long receiver hold-off.
    int hold_req      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // Minute of day of each slot as last configured; steers the stimulus
    // toward times that hit.
    int unsigned alarm_time[ALARM_SLOTS];
    int unsigned last_now = 0;

    always #1 aclk = ~aclk;

    multi_slot_alarm_matcher_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_hour         (s_hour),
        .s_minute       (s_minute),
        .s_window_start (s_window_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fire         (m_fire),
        .m_next_valid   (m_next_valid),
        .m_next_minutes (m_next_minutes),
        .m_next_slot    (m_next_slot)
    );

    // Receiver: stall at random, or hold off for a counted stretch on request.
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor both channels at the edge; the watchdog counts edges with no
    // handshake on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_word({m_fire, m_next_valid, m_next_minutes, m_next_slot});
            if (s_valid && s_ready)
                sb.note_word(op_t'(s_operation), s_hour, s_minute, s_window_start);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** multi_slot_alarm_matcher_unit: FAILED **");
                $finish;
            end
        end
    end

    // Offer one word and return at the edge that accepts it. Valid stays
    // high afterwards; the next call either replaces the payload or drops it.
    task automatic send_word(op_t op, logic [HOUR_W-1:0] hour, logic [MIN_W-1:0] minute,
                             logic [MOD_W-1:0] window_start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_hour         <= hour;
        s_minute       <= minute;
        s_window_start <= window_start;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_at(op_t op, int unsigned now, int unsigned window_start);
        send_word(op, HOUR_W'(now / 60), MIN_W'(now % 60), MOD_W'(window_start));
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    // Drain the block, then write all four registers back to back.
    // Scalar registers get random junk above their used bits.
    task automatic load_config(logic dnd, logic [COUNT_W-1:0] count,
                               logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        write_reg(CFG_DND, {32'($urandom), 31'($urandom), dnd});
        write_reg(CFG_SLOT_COUNT, {32'($urandom), 28'($urandom), count});
        write_reg(CFG_SLOTS_LO, lo);
        write_reg(CFG_SLOTS_HI, hi);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SLOT_BITS-1:0] slot_bits(logic [3:0] pad, logic en,
                                                       logic [HOUR_W-1:0] hour,
                                                       logic [MIN_W-1:0] minute);
        return {pad, en, hour, minute};
    endfunction

    // Build one slot word: mostly live alarms, some ties with the slot
    // below, some disabled, some with an hour or minute out of range.
    function automatic logic [CFG_DATA_W-1:0] random_slots(int base);
        logic [CFG_DATA_W-1:0] word;
        int unsigned           hr, mn;
        logic                  en;
        int                    roll;
        for (int k = 0; k < SLOTS_PER_WORD; k++) begin
            roll = $urandom_range(99);
            hr   = $urandom_range(23);
            mn   = $urandom_range(59);
            en   = 1'b1;
            if (roll < 12 && base + k > 0) begin
                hr = alarm_time[base + k - 1] / 60;
                mn = alarm_time[base + k - 1] % 60;
            end else if (roll < 22) begin
                en = 1'b0;
            end else if (roll < 30) begin
                hr = $urandom_range(31, 24);
            end else if (roll < 38) begin
                mn = $urandom_range(63, 60);
            end
            alarm_time[base + k] = (hr > 23 || mn > 59) ? $urandom_range(DAY_MINUTES - 1)
                                                        : hr * 60 + mn;
            word[k * SLOT_BITS +: SLOT_BITS] = slot_bits(4'($urandom), en, HOUR_W'(hr),
                                                         MIN_W'(mn));
        end
        return word;
    endfunction

    // One random word, mostly aimed at configured alarm times: polls that hit,
    // repeated polls in the same minute, polls a minute later, forgets, windows
    // around an alarm; the rest is raw noise over every field.
    task automatic random_word();
        int unsigned target, now, start;
        int          roll;
        target = alarm_time[$urandom_range(ALARM_SLOTS - 1)];
        roll   = $urandom_range(99);
        if (roll < 35) begin
            last_now = target;
            send_at(OP_POLL, last_now, $urandom_range(2047));
        end else if (roll < 50) begin
            send_at(OP_POLL, last_now, $urandom_range(2047));
        end else if (roll < 60) begin
            last_now = (target + 1) % DAY_MINUTES;
            send_at(OP_POLL, last_now, $urandom_range(2047));
        end else if (roll < 68) begin
            send_at(OP_FORGET, last_now, $urandom_range(2047));
        end else if (roll < 85) begin
            now   = (target + $urandom_range(120)) % DAY_MINUTES;
            start = (target + DAY_MINUTES - $urandom_range(120)) % DAY_MINUTES;
            if ($urandom_range(7) == 0)
                start = now;
            // exercise the wrap of an out-of-range window start
            if (start < 2048 - DAY_MINUTES && $urandom_range(3) == 0)
                start += DAY_MINUTES;
            send_at(OP_WINDOW, now, start);
        end else begin
            send_word(op_t'($urandom_range(3)), HOUR_W'($urandom_range(31)),
                      MIN_W'($urandom_range(63)), MOD_W'($urandom_range(2047)));
        end
    endtask

    initial begin
        logic                  dnd;
        logic [COUNT_W-1:0]    count;
        logic [CFG_DATA_W-1:0] lo, hi;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass. With reset config nothing is enabled.
        send_at(OP_POLL, 450, 0);

        // Slot 0 and 1 tie at 07:30, 2 disabled, 3 hour out of range,
        // 4 minute out of range, 5 at 23:59, 6 at midnight, 7 all ones.
        lo = {slot_bits(4'h0, 1'b1, 25, 10), slot_bits(4'h0, 1'b0, 12, 0),
              slot_bits(4'h0, 1'b1, 7, 30),  slot_bits(4'h0, 1'b1, 7, 30)};
        hi = {16'hFFFF,                      slot_bits(4'h0, 1'b1, 0, 0),
              slot_bits(4'h0, 1'b1, 23, 59), slot_bits(4'h0, 1'b1, 7, 61)};
        load_config(1'b0, 4'd8, lo, hi);
        send_at(OP_POLL, 450, 0);       // fire
        send_at(OP_POLL, 450, 0);       // same minute: hold off
        send_at(OP_FORGET, 450, 0);
        send_at(OP_POLL, 450, 0);       // fire again after forget
        send_at(OP_POLL, 451, 0);       // new minute clears the memory
        send_at(OP_POLL, 450, 0);
        send_word(OP_POLL, 5'd31, 6'd63, 11'd0);        // saturate to 23:59
        send_word(OP_WINDOW, 5'd7, 6'd31, 11'd2047);    // start wraps to 607
        send_at(OP_WINDOW, 451, 451);   // empty window
        send_at(OP_WINDOW, 451, 450);   // alarm on the open edge
        send_at(OP_WINDOW, 1, 1438);    // across midnight
        send_word(OP_NOP, 5'd7, 6'd30, 11'd0);
        send_at(OP_POLL, 720, 0);       // disabled slot
        send_word(OP_POLL, 5'd0, 6'd0, 11'd0);

        load_config(1'b1, 4'd8, lo, hi);
        send_at(OP_POLL, 450, 0);
        send_word(OP_WINDOW, 5'd7, 6'd31, 11'd2047);

        load_config(1'b0, 4'd15, lo, hi);  // count saturates to eight
        send_at(OP_POLL, 1439, 0);

        load_config(1'b0, 4'd1, lo, hi);
        send_at(OP_POLL, 0, 0);
        send_at(OP_WINDOW, 451, 449);

        load_config(1'b0, 4'd0, lo, hi);
        send_at(OP_WINDOW, 451, 449);

        // Random phases; rotate the idling pattern and the config extremes.
        for (int phase = 0; phase < PHASES; phase++) begin
            lo    = random_slots(0);
            hi    = random_slots(SLOTS_PER_WORD);
            dnd   = ($urandom_range(9) == 0);
            count = COUNT_W'($urandom_range(12, 1));
            case (phase)
                0: count = 4'd8;
                1: count = 4'd15;
                2: count = 4'd0;
                3: dnd = 1'b1;
                5: count = 4'd1;
                6: begin
                    lo    = '1;
                    count = 4'd8;
                end
                7: hi = '0;
                default: ;
            endcase
            load_config(dnd, count, lo, hi);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 77;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 77;
                end
                default: begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            // hold the result side while words keep coming, so the input stalls
            if (phase == 4)
                hold_req = HOLD_OFF;
            repeat (PHASE_WORDS) random_word();
        end

        // Drain, then allow for the input and result registers.
        s_valid   <= 1'b0;
        stall_pct  = 0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** multi_slot_alarm_matcher_unit: PASSED **");
        else
            $display("** multi_slot_alarm_matcher_unit: FAILED **");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/msam_pkg.sv
hdl/msam_slot_table.sv
hdl/msam_match.sv
hdl/msam_nearest.sv
hdl/multi_slot_alarm_matcher_unit.sv
tb/sv/msam_tb_pkg.sv
tb/sv/multi_slot_alarm_matcher_unit_tb.sv
